// ===== hdl/dither_pattern_expander_macros.svh =====
// ----------------------------------------------------------------------------
// Dither pattern expander assertion macros
// Shared concurrent assertion shorthands, clocked on clk and muted in reset.
// ----------------------------------------------------------------------------
`ifndef DITHER_PATTERN_EXPANDER_MACROS_SVH
`define DITHER_PATTERN_EXPANDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Dither pattern expander package
// Size codes, dither matrices, threshold steps and the shared item type.
// ----------------------------------------------------------------------------
package dpe_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [7:0] gray_t;
  typedef logic [2:0] idx_t;
  typedef logic [13:0] thr_t;

  localparam mode_t MODE_2X2 = 2'd0;
  localparam mode_t MODE_3X3 = 2'd1;
  localparam mode_t MODE_4X4 = 2'd2;
  localparam mode_t MODE_8X8 = 2'd3;

  // An input item waiting in the buffer stage.
  typedef struct packed {
    logic  valid;
    gray_t gray;
  } item_t;

  // Integer quotient 255 / (n*n + 1) for each size.
  localparam logic [7:0] STEP [4] = '{8'd51, 8'd25, 8'd15, 8'd3};

  // Largest row or column offset, n - 1, for each size.
  localparam idx_t LAST_IDX [4] = '{3'd1, 3'd2, 3'd3, 3'd7};

  localparam logic [5:0] DM2 [2][2] = '{'{6'd0, 6'd2}, '{6'd3, 6'd1}};

  localparam logic [5:0] DM3 [3][3] = '{
    '{6'd0, 6'd7, 6'd3}, '{6'd6, 6'd5, 6'd2}, '{6'd4, 6'd1, 6'd8}};

  localparam logic [5:0] DM4 [4][4] = '{
    '{6'd0,  6'd8,  6'd2,  6'd10}, '{6'd12, 6'd4, 6'd14, 6'd6},
    '{6'd3,  6'd11, 6'd1,  6'd9},  '{6'd15, 6'd7, 6'd13, 6'd5}};

  localparam logic [5:0] DM8 [8][8] = '{
    '{6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63},
    '{6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31},
    '{6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55},
    '{6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23},
    '{6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61},
    '{6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29},
    '{6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53},
    '{6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21}};

  // Threshold for the pixel at (row, col) of the current size.
  function automatic thr_t threshold(mode_t mode, idx_t row, idx_t col);
    logic [5:0] entry;
    begin
      entry = '0;
      case (mode)
        MODE_2X2: entry = DM2[row[0]][col[0]];
        MODE_3X3: begin
          if (row[1:0] != 2'd3 && col[1:0] != 2'd3) begin
            entry = DM3[row[1:0]][col[1:0]];
          end
        end
        MODE_4X4: entry = DM4[row[1:0]][col[1:0]];
        default:  entry = DM8[row][col];
      endcase
      return thr_t'(STEP[mode]) * thr_t'(entry);
    end
  endfunction

endpackage

// ===== hdl/dpe_in_buf.sv =====
// ----------------------------------------------------------------------------
// Dither pattern expander input buffer
// One-entry holding register that takes the next gray item while the
// expander is still emitting the pixels of the current one.
// ----------------------------------------------------------------------------
module dpe_in_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  dpe_pkg::gray_t gray_level,
  input  logic           take,
  output dpe_pkg::item_t item
);

  logic buf_valid;
  dpe_pkg::gray_t buf_gray;
  logic accept;

  assign in_stall = buf_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (accept) begin
      buf_valid <= 1'b1;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_gray <= gray_level;
    end
  end

  assign item.valid = buf_valid;
  assign item.gray  = buf_gray;

endmodule

// ===== hdl/dpe_expander.sv =====
// ----------------------------------------------------------------------------
// Dither pattern expander pixel sequencer
// Walks the n by n block row by row, compares the gray level with each
// threshold and registers one output pixel per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`include "dither_pattern_expander_macros.svh"

module dpe_expander (
  input  logic           clk,
  input  logic           rst,
  input  dpe_pkg::mode_t mode,
  input  dpe_pkg::item_t item,
  output logic           take,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           white,
  output dpe_pkg::idx_t  sub_row,
  output dpe_pkg::idx_t  sub_col,
  output logic           block_last
);

  logic           active;
  dpe_pkg::gray_t gray;
  dpe_pkg::idx_t  row;
  dpe_pkg::idx_t  col;

  logic           adv;
  logic           src_valid;
  dpe_pkg::gray_t src_gray;
  dpe_pkg::idx_t  src_row;
  dpe_pkg::idx_t  src_col;
  dpe_pkg::idx_t  last_idx;
  logic           src_last;
  logic           src_white;

  // The output register moves whenever it is empty or being taken.
  assign adv = !out_valid || !out_stall;

  // A block in progress has priority; otherwise start the buffered item.
  always_comb begin
    if (active) begin
      src_valid = 1'b1;
      src_gray  = gray;
      src_row   = row;
      src_col   = col;
    end else begin
      src_valid = item.valid;
      src_gray  = item.gray;
      src_row   = '0;
      src_col   = '0;
    end
  end

  assign take      = adv && !active && item.valid;
  assign last_idx  = dpe_pkg::LAST_IDX[mode];
  assign src_last  = (src_row == last_idx) && (src_col == last_idx);
  assign src_white = {6'd0, src_gray} >= dpe_pkg::threshold(mode, src_row, src_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= src_valid;
      if (src_valid) begin
        active <= !src_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && src_valid) begin
      gray       <= src_gray;
      white      <= src_white;
      sub_row    <= src_row;
      sub_col    <= src_col;
      block_last <= src_last;
      if (src_col == last_idx) begin
        col <= '0;
        row <= src_row + 3'd1;
      end else begin
        col <= src_col + 3'd1;
        row <= src_row;
      end
    end
  end

  `DPE_ASSERT_SAME(a_last_on_diagonal, out_valid && block_last, sub_row == sub_col,
    "block_last raised off the block corner")
  `DPE_ASSERT_SAME(a_block_in_progress, out_valid && !block_last, active,
    "sequencer went idle before the block was finished")
  `DPE_ASSERT_SAME(a_no_take_mid_block, active, !take,
    "buffered item taken while a block was still in progress")

endmodule

// ===== hdl/dither_pattern_expander.sv =====
// ----------------------------------------------------------------------------
// Dither pattern expander
// Expands each 8-bit gray pixel into an n by n block of binary pixels by
// ordered dithering, with n = 2, 3, 4 or 8 set by the size register.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, gray_level) carries one gray item.
// The output channel (out_valid, out_stall, white, sub_row, sub_col,
// block_last) carries n*n binary pixels per item, row by row, and
// block_last marks the final pixel of each block.
// An accepted gray item enters a one-entry buffer; its first pixel is
// registered into the output register when the sequencer is free.
// The sequencer emits one pixel per cycle while out_stall is low, so a
// block holds n*n pixels (4, 9, 16 or 64). The buffer takes the next
// item while the current block is emitted, and blocks follow each other
// without a gap.
// When the receiver raises out_stall the current pixel holds, the sequencer
// stops, and in_stall rises as soon as the buffer is full.
// Synchronous reset empties the buffer and the output register and sets
// the size register to 2x2. Write the size (cfg_wr_en, cfg_wr_data) only
// while no block is in flight.
// ----------------------------------------------------------------------------
module dither_pattern_expander (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] gray_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       white,
  output logic [2:0] sub_row,
  output logic [2:0] sub_col,
  output logic       block_last
);

  // Size register: 0 = 2x2, 1 = 3x3, 2 = 4x4, 3 = 8x8.
  dpe_pkg::mode_t pattern_size_mode;
  dpe_pkg::item_t item;
  logic           take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_size_mode <= dpe_pkg::MODE_2X2;
    end else if (cfg_wr_en) begin
      pattern_size_mode <= cfg_wr_data;
    end
  end

  // The buffer decouples the sender from the block being emitted.
  dpe_in_buf u_in_buf (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .gray_level (gray_level),
    .take       (take),
    .item       (item)
  );

  // The sequencer walks the block and owns the output register.
  dpe_expander u_expander (
    .clk        (clk),
    .rst        (rst),
    .mode       (pattern_size_mode),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .white      (white),
    .sub_row    (sub_row),
    .sub_col    (sub_col),
    .block_last (block_last)
  );

endmodule
